>>> hw/rtl/murmur2_word_stream_hash_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the word stream hash
// Shared check forms; the using module must have aclk and aresetn in scope.
// ----------------------------------------------------------------------------
`ifndef MURMUR2_WORD_STREAM_HASH_ASSERT_SVH
`define MURMUR2_WORD_STREAM_HASH_ASSERT_SVH

// Same-cycle implication.
`define M2H_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("hash block check failed");

// Next-cycle implication.
`define M2H_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("hash block check failed");

`endif

>>> hw/rtl/m2wsh_pkg.sv
// ----------------------------------------------------------------------------
// m2wsh_pkg
// Constants and controller/datapath interface types for the word stream hash.
// ----------------------------------------------------------------------------
package m2wsh_pkg;

    localparam logic [31:0] MIX_M      = 32'h5bd1e995;
    localparam int          MIX_R      = 24;
    localparam int          AVAL_R1    = 13;
    localparam int          AVAL_R2    = 15;
    localparam logic [31:0] SEED_RESET = 32'd5381;

    // Multiplier operand select codes.
    localparam logic [2:0] MUL_WORD = 3'd0;
    localparam logic [2:0] MUL_KMIX = 3'd1;
    localparam logic [2:0] MUL_H    = 3'd2;
    localparam logic [2:0] MUL_TAIL = 3'd3;
    localparam logic [2:0] MUL_AVAL = 3'd4;

    typedef struct packed {
        logic       cap_in;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic       k_load;
        logic       h_xor_k;
        logic       h_from_mul;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic full_word;
        logic zero_count;
        logic last;
        logic out_busy;
    } sts_t;

endpackage

>>> hw/rtl/murmur2_word_stream_hash.sv
// ----------------------------------------------------------------------------
// murmur2_word_stream_hash
// Seeded 32-bit MurmurHash2 over a key streamed as little-endian words.
// ----------------------------------------------------------------------------
// Usage:
// Key words enter on the s_ channel. The word marked by s_tuser (first word)
// restarts the hash at the seed XOR the key length; s_tlast marks the final
// word, after which one finished hash leaves on the m_ channel. The seed is
// written through cfg_wr_en / cfg_wr_data; the user must write it only while
// the block is idle; the block itself does not enforce this. Words run through
// one shared 32-bit constant multiplier, so the time between accepted words
// depends on the byte count: a full word takes three multiplies, a 1 to 3
// byte tail one and an empty word none. A last word adds the avalanche
// multiply; the hash shows on m_tvalid as the block returns to idle. The
// next word is taken while a hash waits on m_tready; a new hash waits in the
// block until the previous one is taken.
// Reset sets the seed to 5381, clears the accumulator and drops m_tvalid.
// ----------------------------------------------------------------------------
module murmur2_word_stream_hash (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // data_word[31:0], byte_count[34:32], key_length[66:35]
    input  logic        s_tuser,   // first_word
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // hash_value[31:0]
);

    m2wsh_pkg::cmd_t cmd;
    m2wsh_pkg::sts_t sts;

    m2wsh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts_i    (sts),
        .cmd_o    (cmd)
    );

    m2wsh_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_data_word  (s_tdata[31:0]),
        .in_byte_count (s_tdata[34:32]),
        .in_first_word (s_tuser),
        .in_last_word  (s_tlast),
        .in_key_length (s_tdata[66:35]),
        .cmd_i         (cmd),
        .sts_o         (sts),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

endmodule

>>> hw/rtl/m2wsh_dp.sv
// ----------------------------------------------------------------------------
// m2wsh_dp
// Datapath: seed and accumulator registers, one shared constant multiplier
// with a result register, and the output register.
// ----------------------------------------------------------------------------
module m2wsh_dp (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data,
    input  logic [31:0]        in_data_word,
    input  logic [2:0]         in_byte_count,
    input  logic               in_first_word,
    input  logic               in_last_word,
    input  logic [31:0]        in_key_length,
    input  m2wsh_pkg::cmd_t    cmd_i,
    output m2wsh_pkg::sts_t    sts_o,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata
);

    logic [31:0] seed_reg;
    logic [31:0] h_reg, h_next;
    logic [31:0] word_reg;
    logic [2:0]  count_reg;
    logic        last_reg;
    logic [31:0] mul_reg;
    logic [31:0] k_reg;
    logic [31:0] out_reg;
    logic        out_valid_reg, out_valid_next;

    logic [31:0] mul_op;
    logic [31:0] product;
    logic [31:0] tail_bits;

    always_comb begin
        tail_bits = {24'd0, word_reg[7:0]};
        if (count_reg >= 3'd2) begin
            tail_bits[15:8] = word_reg[15:8];
        end
        if (count_reg == 3'd3) begin
            tail_bits[23:16] = word_reg[23:16];
        end
    end

    always_comb begin
        case (cmd_i.mul_sel)
            m2wsh_pkg::MUL_WORD: mul_op = word_reg;
            m2wsh_pkg::MUL_KMIX: mul_op = mul_reg ^ (mul_reg >> m2wsh_pkg::MIX_R);
            m2wsh_pkg::MUL_H:    mul_op = h_reg;
            m2wsh_pkg::MUL_TAIL: mul_op = h_reg ^ tail_bits;
            m2wsh_pkg::MUL_AVAL: mul_op = h_reg ^ (h_reg >> m2wsh_pkg::AVAL_R1);
            default:             mul_op = h_reg;
        endcase
    end

    // Only the low 32 bits of the product are kept.
    assign product = mul_op * m2wsh_pkg::MIX_M;

    always_comb begin
        h_next = h_reg;
        if (cmd_i.cap_in) begin
            h_next = in_first_word ? (seed_reg ^ in_key_length) : h_reg;
        end else if (cmd_i.h_xor_k) begin
            h_next = mul_reg ^ k_reg;
        end else if (cmd_i.h_from_mul) begin
            h_next = mul_reg;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd_i.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg      <= m2wsh_pkg::SEED_RESET;
            h_reg         <= 32'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                seed_reg <= cfg_wr_data;
            end
            h_reg         <= h_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.cap_in) begin
            word_reg  <= in_data_word;
            count_reg <= in_byte_count;
            last_reg  <= in_last_word;
        end
        if (cmd_i.mul_en) begin
            mul_reg <= product;
        end
        if (cmd_i.k_load) begin
            k_reg <= mul_reg;
        end
        if (cmd_i.out_load) begin
            out_reg <= mul_reg ^ (mul_reg >> m2wsh_pkg::AVAL_R2);
        end
    end

    // Counts of four to seven are taken as a full word.
    assign sts_o.full_word  = count_reg[2];
    assign sts_o.zero_count = (count_reg == 3'd0);
    assign sts_o.last       = last_reg;
    assign sts_o.out_busy   = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

>>> hw/rtl/m2wsh_ctrl.sv
// ----------------------------------------------------------------------------
// m2wsh_ctrl
// Controller: sequences the shared multiplier through the word mix, the tail
// fold and the final avalanche, and handles the input handshake.
// ----------------------------------------------------------------------------
`include "murmur2_word_stream_hash_assert.svh"

module m2wsh_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  m2wsh_pkg::sts_t    sts_i,
    output m2wsh_pkg::cmd_t    cmd_o
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_K1       = 4'd2;
    localparam logic [3:0] S_K2       = 4'd3;
    localparam logic [3:0] S_K3       = 4'd4;
    localparam logic [3:0] S_HUPD     = 4'd5;
    localparam logic [3:0] S_T1       = 4'd6;
    localparam logic [3:0] S_T2       = 4'd7;
    localparam logic [3:0] S_AV1      = 4'd8;
    localparam logic [3:0] S_AV2      = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next        = state_reg;
        cmd_o             = '0;
        cmd_o.mul_sel     = m2wsh_pkg::MUL_WORD;
        cmd_o.cap_in      = accept;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (sts_i.full_word) begin
                    state_next = S_K1;
                end else if (!sts_i.zero_count) begin
                    state_next = S_T1;
                end else begin
                    state_next = sts_i.last ? S_AV1 : S_IDLE;
                end
            end
            S_K1: begin
                cmd_o.mul_en  = 1'b1;
                cmd_o.mul_sel = m2wsh_pkg::MUL_WORD;
                state_next    = S_K2;
            end
            S_K2: begin
                cmd_o.mul_en  = 1'b1;
                cmd_o.mul_sel = m2wsh_pkg::MUL_KMIX;
                state_next    = S_K3;
            end
            S_K3: begin
                // The mixed word moves aside while h*m takes the multiplier.
                cmd_o.k_load  = 1'b1;
                cmd_o.mul_en  = 1'b1;
                cmd_o.mul_sel = m2wsh_pkg::MUL_H;
                state_next    = S_HUPD;
            end
            S_HUPD: begin
                cmd_o.h_xor_k = 1'b1;
                state_next    = sts_i.last ? S_AV1 : S_IDLE;
            end
            S_T1: begin
                cmd_o.mul_en  = 1'b1;
                cmd_o.mul_sel = m2wsh_pkg::MUL_TAIL;
                state_next    = S_T2;
            end
            S_T2: begin
                cmd_o.h_from_mul = 1'b1;
                state_next       = sts_i.last ? S_AV1 : S_IDLE;
            end
            S_AV1: begin
                cmd_o.mul_en  = 1'b1;
                cmd_o.mul_sel = m2wsh_pkg::MUL_AVAL;
                state_next    = S_AV2;
            end
            S_AV2: begin
                // Wait here while the previous hash is still unclaimed.
                if (!sts_i.out_busy) begin
                    cmd_o.out_load = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `M2H_ASSERT_IMP(a_out_load_free, cmd_o.out_load, !sts_i.out_busy)
    `M2H_ASSERT_NXT(a_accept_dispatch, accept, state_reg == S_DISPATCH)
    `M2H_ASSERT_IMP(a_hupd_after_k3, state_reg == S_HUPD, $past(state_reg) == S_K3)
    `M2H_ASSERT_IMP(a_one_h_write, cmd_o.h_xor_k || cmd_o.h_from_mul, !cmd_o.cap_in)

endmodule
